@@ rtl/splu_pkg.sv @@
// ----------------------------------------------------------------------------
// splu_pkg: shared definitions for the preference softplus loss block
// Widths, register codes, sequencer states, interface structs and the
// softplus table, which is built at elaboration from exact integer arithmetic.
// ----------------------------------------------------------------------------
package splu_pkg;

    // Block constants.
    localparam int MAX_BATCH     = 65536;
    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 256;

    // Field widths.
    localparam int LP_W       = 32;
    localparam int BETA_W     = 24;
    localparam int GAMMA_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int MEAN_W     = 31;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = $clog2(MAX_BATCH + 1);
    localparam int DIVCNT_W   = $clog2(SUM_W + 1);

    // Margin difference: chosen - rejected - gamma needs 34 signed bits,
    // its magnitude stays below 2^33.
    localparam int D_W      = LP_W + 2;
    localparam int AD_W     = LP_W + 1;
    localparam int AD_LO_W  = 17;
    localparam int AD_HI_W  = AD_W - AD_LO_W;
    localparam int FULL_W   = BETA_W + AD_W;
    localparam int MAG_W    = FULL_W - FRAC_BITS;

    // Table geometry: the table spans [0,16) with TABLE_ENTRIES intervals.
    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int RANGE_SH  = FRAC_BITS + 4;
    localparam int STEP_BITS = RANGE_SH - IDX_W;
    localparam int SP_W      = FRAC_BITS;

    // Shared multiplier operand widths.
    localparam int MA_W = BETA_W;
    localparam int MB_W = (STEP_BITS > AD_LO_W) ? STEP_BITS : AD_LO_W;
    localparam int P_W  = MA_W + MB_W;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_BETA_SCALE   = 1'b0,
        REG_GAMMA_MARGIN = 1'b1
    } cfg_reg_e;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MAG,
        S_LOOK,
        S_TERM,
        S_ACC,
        S_DIV,
        S_HOLD
    } state_e;

    // Operands for the shared multiplier.
    typedef struct packed {
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } mul_req_t;

    // Divider control and status.
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [TABLE_ENTRIES-1:0][SP_W-1:0] sp_table_t;

    // Q30 constants for the table build.
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF  = 64'd1 << 29;
    localparam logic [63:0] Q30_INV_E = 64'd395007542;

    // Unsigned 64-bit quotient by shift and subtract. It only runs while the
    // table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-x) in Q30: Taylor series on the fraction, powers of 1/e for the
    // integer part; the 1/e powers and the final product are rounded.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] xq);
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] ef;
        logic [63:0] p;
        n    = xq >> 30;
        f    = xq & (Q30_ONE - 64'd1);
        term = Q30_ONE;
        ef   = Q30_ONE;
        p    = Q30_ONE;
        for (int k = 1; k <= 20; k++)
        begin
            term = udiv64((term * f) >> 30, 64'(k));
            if ((k % 2) == 1)
                ef = ef - term;
            else
                ef = ef + term;
        end
        for (int k = 0; k < 16; k++)
        begin
            if (64'(k) < n)
                p = (p * Q30_INV_E + Q30_HALF) >> 30;
        end
        return (p * ef + Q30_HALF) >> 30;
    endfunction

    // log(1+y) in Q30 for y in [0,1] through the atanh series.
    function automatic logic [63:0] log1p_q30(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] s;
        logic [63:0] pw;
        z  = udiv64(y << 30, (Q30_ONE << 1) + y);
        z2 = (z * z) >> 30;
        s  = z;
        pw = z;
        for (int k = 3; k <= 41; k += 2)
        begin
            pw = (pw * z2) >> 30;
            s  = s + udiv64(pw, 64'(k));
        end
        return s << 1;
    endfunction

    // Entry i holds log(1+exp(-16*i/TABLE_ENTRIES)) rounded to FRAC_BITS.
    function automatic sp_table_t build_sp_table();
        sp_table_t   t;
        logic [63:0] xq;
        logic [63:0] l;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            xq   = (64'(16 * i) << 30) >> IDX_W;
            l    = log1p_q30(exp_neg_q30(xq));
            t[i] = SP_W'((l + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        end
        return t;
    endfunction

    localparam sp_table_t SP_TABLE = build_sp_table();

endpackage

@@ rtl/splu_mul.sv @@
// ----------------------------------------------------------------------------
// splu_mul: shared unsigned multiplier
// One product per cycle, registered; used for both halves of the margin
// scaling and for the table interpolation.
// ----------------------------------------------------------------------------
module splu_mul (
    input  logic                clk,
    input  splu_pkg::mul_req_t  req,
    output logic [splu_pkg::P_W-1:0] prod
);
    import splu_pkg::*;

    logic [P_W-1:0] prod_reg;
    logic [P_W-1:0] prod_next;

    // Full-width product of the two operands.
    always_comb
    begin
        prod_next = P_W'(req.a) * P_W'(req.b);
    end

    // Product register.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/splu_div.sv @@
// ----------------------------------------------------------------------------
// splu_div: serial restoring divider
// Divides the batch sum by the pair count, one quotient bit per cycle.
// The quotient holds until the next start.
// ----------------------------------------------------------------------------
module splu_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  splu_pkg::div_req_t            req,
    input  logic [splu_pkg::SUM_W-1:0]    dividend,
    input  logic [splu_pkg::CNT_W-1:0]    divisor,
    output splu_pkg::div_stat_t           stat,
    output logic [splu_pkg::SUM_W-1:0]    quotient
);
    import splu_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [DIVCNT_W-1:0] cnt_reg;
    logic [DIVCNT_W-1:0] cnt_next;
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    quo_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]    dvs_next;
    logic [CNT_W:0]      shifted;
    logic                qbit;

    // One restoring step per cycle while busy.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        qbit      = (shifted >= {1'b0, dvs_reg});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVCNT_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (qbit)
                rem_next = CNT_W'(shifted - {1'b0, dvs_reg});
            else
                rem_next = CNT_W'(shifted);
            quo_next = {quo_reg[SUM_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ rtl/preference_softplus_loss_mean.sv @@
// ----------------------------------------------------------------------------
// preference_softplus_loss_mean: mean softplus preference loss over a batch
//
// Input channel (in_valid/in_ready) carries one pair of chosen and rejected
// log-probabilities in signed Q16.16 and a last_pair mark. Each transaction
// forms diff = beta_scale*(chosen - rejected - gamma_margin) and adds
// softplus(-diff), taken from a 256-entry table with linear interpolation,
// into a saturating 48-bit sum. The output channel (out_valid/out_ready)
// carries one transaction per batch: the mean term and a saturation flag.
// One pair occupies the block through accept, two multiplier passes for
// the scaling, magnitude, table lookup with interpolation multiply, term
// and accumulate; the scaling and interpolation share one multiplier.
// After a last pair the block runs the serial divide, one quotient bit per
// cycle, sees the divider finish in S_DIV and loads the mean into the
// output register in S_HOLD.
// The block accepts the next batch while a mean waits in the output register;
// if a second mean is ready before the first is taken, the block holds in
// place and stops accepting until out_ready frees the register.
// Reset clears the sum, count and running saturation flag, sets beta_scale to 1.0 and
// gamma_margin to 0. The table is constant logic and needs no fill.
// Configuration writes (cfg_write_en) take effect at once.
// ----------------------------------------------------------------------------
module preference_softplus_loss_mean (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic                              cfg_index,
    input  logic [splu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [splu_pkg::LP_W-1:0]  chosen_logprob,
    input  logic signed [splu_pkg::LP_W-1:0]  rejected_logprob,
    input  logic                              last_pair,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [splu_pkg::MEAN_W-1:0]       mean_loss,
    output logic                              saturated
);
    import splu_pkg::*;

    // Sequencer and control state.
    state_e              state_reg;
    state_e              state_next;
    logic [BETA_W-1:0]   beta_reg;
    logic [GAMMA_W-1:0]  gamma_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                sat_reg;
    logic                sat_next;
    logic                div_sat_reg;
    logic                div_sat_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    // Per-pair datapath registers.
    logic [AD_W-1:0]     ad_reg;
    logic                neg_reg;
    logic                last_reg;
    logic [P_W-1:0]      lo_prod_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [SP_W-1:0]     a_reg;
    logic                up_reg;
    logic                in_range_reg;
    logic [MEAN_W-1:0]   term_reg;
    logic                term_sat_reg;
    logic [MEAN_W-1:0]   mean_reg;
    logic                flag_reg;

    // Combinational values.
    logic                in_fire;
    logic signed [D_W-1:0] d_full;
    logic [AD_W-1:0]     ad_val;
    logic [FULL_W-1:0]   full_prod;
    logic [IDX_W-1:0]    idx;
    logic [SP_W-1:0]     tab_a;
    logic [SP_W-1:0]     tab_b;
    logic [SP_W-1:0]     tab_diff;
    logic                tab_up;
    logic                mag_in_range;
    logic [SP_W-1:0]     step;
    logic [SP_W-1:0]     interp;
    logic [MAG_W:0]      term_wide;
    logic                term_over;
    logic [MEAN_W-1:0]   term_val;
    logic [SUM_W:0]      sum_add;
    logic                sum_over;
    logic [SUM_W-1:0]    sum_acc;
    logic                count_full;
    logic [CNT_W-1:0]    count_acc;
    logic                sat_acc;
    logic                out_free;
    logic                mean_over;
    logic [MEAN_W-1:0]   mean_val;

    mul_req_t            mul_req;
    logic [P_W-1:0]      mul_prod;
    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [SUM_W-1:0]    div_quo;

    // Shared multiplier.
    splu_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // Serial divider for the batch mean.
    splu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (sum_acc),
        .divisor  (count_acc),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign mean_loss = mean_reg;
    assign saturated = flag_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Margin difference and its magnitude at accept.
    always_comb
    begin
        d_full = D_W'(chosen_logprob) - D_W'(rejected_logprob)
                 - D_W'($signed(gamma_reg));
        if (d_full[D_W-1])
            ad_val = AD_W'(-d_full);
        else
            ad_val = AD_W'(d_full);
    end

    // Scaled magnitude from the two partial products.
    always_comb
    begin
        full_prod = (FULL_W'(mul_prod) << AD_LO_W) + FULL_W'(lo_prod_reg);
    end

    // Table lookup: neighboring entries and their distance.
    always_comb
    begin
        mag_in_range = ((mag_reg >> RANGE_SH) == '0);
        idx          = mag_reg[STEP_BITS +: IDX_W];
        tab_a        = SP_TABLE[idx];
        if (idx == IDX_W'(TABLE_ENTRIES - 1))
            tab_b = '0;
        else
            tab_b = SP_TABLE[IDX_W'(idx + 1'b1)];
        tab_up = (tab_b > tab_a);
        if (tab_up)
            tab_diff = tab_b - tab_a;
        else
            tab_diff = tab_a - tab_b;
    end

    // Loss term: interpolated log part plus the magnitude for a negative diff.
    always_comb
    begin
        step = SP_W'(mul_prod >> STEP_BITS);
        if (up_reg)
            interp = a_reg + step;
        else
            interp = a_reg - step;
        term_wide = (in_range_reg ? (MAG_W + 1)'(interp) : '0)
                    + (neg_reg ? (MAG_W + 1)'(mag_reg) : '0);
        term_over = (term_wide[MAG_W:MEAN_W] != '0);
        term_val  = term_over ? '1 : term_wide[MEAN_W-1:0];
    end

    // Saturating accumulation and pair count.
    always_comb
    begin
        sum_add    = {1'b0, sum_reg} + (SUM_W + 1)'(term_reg);
        sum_over   = sum_add[SUM_W];
        sum_acc    = sum_over ? '1 : sum_add[SUM_W-1:0];
        count_full = (count_reg == CNT_W'(MAX_BATCH));
        count_acc  = count_full ? count_reg : CNT_W'(count_reg + 1'b1);
        sat_acc    = sat_reg || term_sat_reg || sum_over || count_full;
    end

    // Clamped mean from the quotient.
    always_comb
    begin
        mean_over = (div_quo[SUM_W-1:MEAN_W] != '0);
        mean_val  = mean_over ? '1 : div_quo[MEAN_W-1:0];
    end

    // Sequencer: next state, multiplier operands, divider start, sum, count and output valid.
    always_comb
    begin
        state_next     = state_reg;
        mul_req.a      = beta_reg;
        mul_req.b      = '0;
        div_req.start  = 1'b0;
        sum_next       = sum_reg;
        count_next     = count_reg;
        sat_next       = sat_reg;
        div_sat_next   = div_sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                mul_req.b  = MB_W'(ad_reg[AD_LO_W-1:0]);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                mul_req.b  = MB_W'(ad_reg[AD_W-1:AD_LO_W]);
                state_next = S_MAG;
            end
            S_MAG:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                mul_req.a  = MA_W'(tab_diff);
                mul_req.b  = MB_W'(mag_reg[STEP_BITS-1:0]);
                state_next = S_TERM;
            end
            S_TERM:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (last_reg)
                begin
                    div_req.start = 1'b1;
                    div_sat_next  = sat_acc;
                    sum_next      = '0;
                    count_next    = '0;
                    sat_next      = 1'b0;
                    state_next    = S_DIV;
                end
                else
                begin
                    sum_next   = sum_acc;
                    count_next = count_acc;
                    sat_next   = sat_acc;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg      <= BETA_W'(65536);
            gamma_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
            div_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BETA_SCALE:   beta_reg  <= cfg_data[BETA_W-1:0];
                    REG_GAMMA_MARGIN: gamma_reg <= cfg_data[GAMMA_W-1:0];
                    default:          ;
                endcase
            end
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            sat_reg       <= sat_next;
            div_sat_reg   <= div_sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-pair datapath and output registers, each loaded in the state that produces it.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ad_reg   <= ad_val;
            neg_reg  <= d_full[D_W-1];
            last_reg <= last_pair;
        end
        if (state_reg == S_MUL_HI)
            lo_prod_reg <= mul_prod;
        if (state_reg == S_MAG)
            mag_reg <= full_prod[FULL_W-1:FRAC_BITS];
        if (state_reg == S_LOOK)
        begin
            a_reg        <= tab_a;
            up_reg       <= tab_up;
            in_range_reg <= mag_in_range;
        end
        if (state_reg == S_TERM)
        begin
            term_reg     <= term_val;
            term_sat_reg <= term_over;
        end
        if ((state_reg == S_HOLD) && out_free)
        begin
            mean_reg <= mean_val;
            flag_reg <= div_sat_reg || mean_over;
        end
    end

endmodule
